[sv/quaternion_alu_macros.svh]
// assertion macros for the quaternion arithmetic unit
// clocked by clock and disabled by reset of the including module
`ifndef QUATERNION_ALU_MACROS_SVH
`define QUATERNION_ALU_MACROS_SVH

// same-cycle implication
`define QALU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QALU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/qalu_pkg.sv]
// shared widths, opcodes and status codes of the quaternion arithmetic unit
// no dependencies
`default_nettype none

package qalu_pkg;

   localparam int DATA_W        = 32;
   localparam int CMD_W         = 3;
   localparam int STAT_W        = 2;
   localparam int LANES         = 4;
   localparam int TERMS         = 4;
   localparam int PROD_W        = 64;
   localparam int ACC_W         = 67;
   localparam int QUO_W         = 34;
   localparam int DIV_LAT       = QUO_W + 1;
   localparam int FRAC_BITS_DEF = 16;
   localparam int REQ_DATA_W    = 9 * DATA_W;
   localparam int RSP_DATA_W    = LANES * DATA_W;

   localparam logic [CMD_W-1:0] CMD_MUL   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SUB   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SCALE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DIV   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CONJ  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_NORM  = 3'd6;
   localparam logic [CMD_W-1:0] CMD_INV   = 3'd7;

   localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_DZ  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_OVF = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0] quo;
      logic              ovf;
   } div_out_type;

endpackage

`default_nettype wire

[sv/qalu_div.sv]
// one lane of the pipelined fixed-point divider, one quotient bit per stage
// depends on qalu_pkg
`default_nettype none

module qalu_div #(
   parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 en,
   input  wire logic signed [qalu_pkg::DATA_W-1:0]   num,
   input  wire logic signed [qalu_pkg::DATA_W-1:0]   den,
   output qalu_pkg::div_out_type                     result
);

   localparam int DW = qalu_pkg::DATA_W;
   localparam int QW = qalu_pkg::QUO_W;
   localparam int PW = qalu_pkg::PROD_W;
   localparam logic [QW-1:0] NEG_LIM = QW'(1) << (DW - 1);
   localparam logic [QW-1:0] POS_LIM = NEG_LIM - QW'(1);
   localparam logic [DW-1:0] MAXV    = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINV    = {1'b1, {(DW-1){1'b0}}};

   logic [DW-1:0] mag_num, mag_den;
   logic [PW-1:0] dvd;
   logic [DW-1:0] rem0_in;

   // stage k holds the partial remainder and a word whose top bits are
   // the unused dividend bits and whose low bits are quotient bits
   logic [DW-1:0] rem_ff [0:QW];
   logic [QW-1:0] sh_ff  [0:QW];
   logic [DW-1:0] den_ff [0:QW];
   logic          neg_ff [0:QW];
   logic          ovf_ff [0:QW];
   logic [DW-1:0] rem_in [0:QW-1];
   logic          ge_in  [0:QW-1];

   logic [QW:0]   rnd;
   logic [QW-1:0] q;

   always_comb begin
      mag_num = num[DW-1] ? (~num + 1'b1) : num;
      mag_den = den[DW-1] ? (~den + 1'b1) : den;
      // twice the scaled dividend, so the last quotient bit is the round bit
      dvd     = PW'(mag_num) << (FRAC_BITS + 1);
      rem0_in = DW'(dvd[PW-1:QW]);
   end

   genvar gk;
   generate
      for (gk = 0; gk < QW; gk++) begin : g_step
         logic [DW:0] trial, diff;
         always_comb begin
            trial      = {rem_ff[gk], sh_ff[gk][QW-1]};
            diff       = trial - {1'b0, den_ff[gk]};
            ge_in[gk]  = trial >= {1'b0, den_ff[gk]};
            rem_in[gk] = ge_in[gk] ? diff[DW-1:0] : trial[DW-1:0];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem0_in;
         sh_ff[0]  <= dvd[QW-1:0];
         den_ff[0] <= mag_den;
         neg_ff[0] <= num[DW-1] ^ den[DW-1];
         ovf_ff[0] <= rem0_in >= mag_den;
         for (int k = 0; k < QW; k++) begin
            rem_ff[k+1] <= rem_in[k];
            sh_ff[k+1]  <= {sh_ff[k][QW-2:0], ge_in[k]};
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   always_comb begin
      rnd = {1'b0, sh_ff[QW]} + (QW+1)'(1);
      q   = rnd[QW:1];
      if (ovf_ff[QW] || (neg_ff[QW] ? (q > NEG_LIM) : (q > POS_LIM))) begin
         result.quo = neg_ff[QW] ? MINV : MAXV;
         result.ovf = 1'b1;
      end else begin
         result.quo = neg_ff[QW] ? (~q[DW-1:0] + 1'b1) : q[DW-1:0];
         result.ovf = 1'b0;
      end
   end

endmodule

`default_nettype wire

[sv/quaternion_alu.sv]
// Quaternion arithmetic unit on signed fixed-point words: product, add, subtract, scale,
// divide by scalar, conjugate, squared norm and inverse. One beat is taken every clock while
// the skid entry of the output buffer is empty; a request passes the input register, four
// multiply and accumulate stages, 35 divider stages (an entry register, then one quotient
// bit each) and the output register. Every opcode runs the same pipeline; non-dividing
// ones pass through the divider over 1.0.
// depends on qalu_pkg, qalu_div and quaternion_alu_macros.svh
`default_nettype none
`include "quaternion_alu_macros.svh"

module quaternion_alu #(
   parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // left_x, left_y, left_z, left_w, right_x, right_y, right_z, right_w, scalar_value
   input  wire logic [qalu_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd
   input  wire logic [qalu_pkg::CMD_W-1:0]         req_tuser,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // res_x, res_y, res_z, res_w
   output      logic [qalu_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status
   output      logic [qalu_pkg::STAT_W-1:0]        rsp_tuser
);

   localparam int DW = qalu_pkg::DATA_W;
   localparam int NL = qalu_pkg::LANES;
   localparam int NT = qalu_pkg::TERMS;
   localparam int PW = qalu_pkg::PROD_W;
   localparam int AW = qalu_pkg::ACC_W;
   localparam int DL = qalu_pkg::DIV_LAT;
   localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;
   localparam logic signed [AW-1:0] RND = AW'(1) << (FRAC_BITS - 1);
   localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

   logic en;

   // stage 1: request
   logic                          v_ff   [1:5];
   logic [qalu_pkg::CMD_W-1:0]    cmd_ff [1:5];
   logic signed [DW-1:0]          s_ff   [1:5];
   logic signed [DW-1:0]          wl_ff  [2:5];
   logic signed [DW-1:0]          l1_ff  [NL];
   logic signed [DW-1:0]          r1_ff  [NL];

   // operand selection
   logic signed [DW-1:0]          a_op   [NL][NT];
   logic signed [DW-1:0]          b_op   [NL][NT];
   logic                          n_op   [NL][NT];

   // accumulate stages
   logic signed [PW-1:0]          prod2_ff [NL][NT];
   logic                          neg2_ff  [NL][NT];
   logic signed [AW-1:0]          term_in  [NL][NT];
   logic signed [AW-1:0]          pair3_ff [NL][2];
   logic signed [AW-1:0]          sum4_ff  [NL];
   logic signed [AW-1:0]          sh_in    [NL];
   logic signed [DW-1:0]          mac5_in  [NL];
   logic                          mov5_in  [NL];
   logic signed [DW-1:0]          mac5_ff  [NL];
   logic                          mov5_ff  [NL];

   // divider feed and sideband
   logic                          is_div, is_inv;
   logic signed [DW-1:0]          den_in;
   logic signed [DW-1:0]          num_in [NL];
   logic                          dz_in, ov_in;
   logic                          sb_v_ff  [0:DL-1];
   logic                          sb_dz_ff [0:DL-1];
   logic                          sb_ov_ff [0:DL-1];
   qalu_pkg::div_out_type         dout [NL];

   // result and output buffer
   logic                          deliver;
   logic [qalu_pkg::RSP_DATA_W-1:0] res_in;
   logic [qalu_pkg::STAT_W-1:0]   stat_in;
   logic                          any_ovf;
   logic                          out_valid_ff, skid_valid_ff;
   logic [qalu_pkg::RSP_DATA_W-1:0] out_data_ff, skid_data_ff;
   logic [qalu_pkg::STAT_W-1:0]   out_stat_ff, skid_stat_ff;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   always_comb begin
      for (int c = 0; c < NL; c++) begin
         for (int k = 0; k < NT; k++) begin
            a_op[c][k] = '0;
            b_op[c][k] = '0;
            n_op[c][k] = 1'b0;
         end
      end
      case (cmd_ff[1])
         qalu_pkg::CMD_MUL: begin
            a_op[0][0] = l1_ff[1]; b_op[0][0] = r1_ff[2];
            a_op[0][1] = l1_ff[2]; b_op[0][1] = r1_ff[1]; n_op[0][1] = 1'b1;
            a_op[0][2] = r1_ff[3]; b_op[0][2] = l1_ff[0];
            a_op[0][3] = l1_ff[3]; b_op[0][3] = r1_ff[0];
            a_op[1][0] = l1_ff[2]; b_op[1][0] = r1_ff[0];
            a_op[1][1] = l1_ff[0]; b_op[1][1] = r1_ff[2]; n_op[1][1] = 1'b1;
            a_op[1][2] = r1_ff[3]; b_op[1][2] = l1_ff[1];
            a_op[1][3] = l1_ff[3]; b_op[1][3] = r1_ff[1];
            a_op[2][0] = l1_ff[0]; b_op[2][0] = r1_ff[1];
            a_op[2][1] = l1_ff[1]; b_op[2][1] = r1_ff[0]; n_op[2][1] = 1'b1;
            a_op[2][2] = r1_ff[3]; b_op[2][2] = l1_ff[2];
            a_op[2][3] = l1_ff[3]; b_op[2][3] = r1_ff[2];
            a_op[3][0] = l1_ff[3]; b_op[3][0] = r1_ff[3];
            a_op[3][1] = l1_ff[0]; b_op[3][1] = r1_ff[0]; n_op[3][1] = 1'b1;
            a_op[3][2] = l1_ff[1]; b_op[3][2] = r1_ff[1]; n_op[3][2] = 1'b1;
            a_op[3][3] = l1_ff[2]; b_op[3][3] = r1_ff[2]; n_op[3][3] = 1'b1;
         end
         qalu_pkg::CMD_ADD, qalu_pkg::CMD_SUB: begin
            // sums run through the multipliers as products with 1.0
            for (int c = 0; c < NL; c++) begin
               a_op[c][0] = l1_ff[c]; b_op[c][0] = ONE;
               a_op[c][1] = r1_ff[c]; b_op[c][1] = ONE;
               n_op[c][1] = cmd_ff[1] == qalu_pkg::CMD_SUB;
            end
         end
         qalu_pkg::CMD_SCALE: begin
            for (int c = 0; c < NL; c++) begin
               a_op[c][0] = l1_ff[c]; b_op[c][0] = s_ff[1];
            end
         end
         qalu_pkg::CMD_DIV: begin
            for (int c = 0; c < NL; c++) begin
               a_op[c][0] = l1_ff[c]; b_op[c][0] = ONE;
            end
         end
         qalu_pkg::CMD_CONJ: begin
            for (int c = 0; c < NL - 1; c++) begin
               a_op[c][0] = l1_ff[c]; b_op[c][0] = ONE; n_op[c][0] = 1'b1;
            end
            a_op[3][0] = l1_ff[3]; b_op[3][0] = ONE;
         end
         qalu_pkg::CMD_NORM: begin
            for (int k = 0; k < NT; k++) begin
               a_op[3][k] = l1_ff[k]; b_op[3][k] = l1_ff[k];
            end
         end
         qalu_pkg::CMD_INV: begin
            // conjugate in lanes x..z, squared norm in the real lane
            for (int c = 0; c < NL - 1; c++) begin
               a_op[c][0] = l1_ff[c]; b_op[c][0] = ONE; n_op[c][0] = 1'b1;
            end
            for (int k = 0; k < NT; k++) begin
               a_op[3][k] = l1_ff[k]; b_op[3][k] = l1_ff[k];
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      for (int c = 0; c < NL; c++) begin
         for (int k = 0; k < NT; k++) begin
            term_in[c][k] = neg2_ff[c][k] ? -AW'(prod2_ff[c][k]) : AW'(prod2_ff[c][k]);
         end
         sh_in[c] = sum4_ff[c] >>> FRAC_BITS;
         // in range when every bit above the 32-bit sign matches it
         if ((&sh_in[c][AW-1:DW-1]) || !(|sh_in[c][AW-1:DW-1])) begin
            mac5_in[c] = sh_in[c][DW-1:0];
            mov5_in[c] = 1'b0;
         end else begin
            mac5_in[c] = sh_in[c][AW-1] ? MINV : MAXV;
            mov5_in[c] = 1'b1;
         end
      end
   end

   always_comb begin
      is_div = cmd_ff[5] == qalu_pkg::CMD_DIV;
      is_inv = cmd_ff[5] == qalu_pkg::CMD_INV;
      den_in = is_div ? s_ff[5] : (is_inv ? mac5_ff[3] : ONE);
      for (int c = 0; c < NL - 1; c++) begin
         num_in[c] = mac5_ff[c];
      end
      num_in[3] = is_inv ? wl_ff[5] : mac5_ff[3];
      dz_in     = (is_div || is_inv) && den_in == '0;
      ov_in     = mov5_ff[0] || mov5_ff[1] || mov5_ff[2] || mov5_ff[3];
   end

   genvar gl;
   generate
      for (gl = 0; gl < NL; gl++) begin : g_lane
         qalu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .clock  (clock),
            .en     (en),
            .num    (num_in[gl]),
            .den    (den_in),
            .result (dout[gl])
         );
      end
   endgenerate

   always_comb begin
      deliver = sb_v_ff[DL-1] && en;
      any_ovf = dout[0].ovf || dout[1].ovf || dout[2].ovf || dout[3].ovf;
      if (sb_dz_ff[DL-1]) begin
         res_in  = '0;
         stat_in = qalu_pkg::STAT_DZ;
      end else begin
         res_in  = {dout[3].quo, dout[2].quo, dout[1].quo, dout[0].quo};
         stat_in = (sb_ov_ff[DL-1] || any_ovf) ? qalu_pkg::STAT_OVF : qalu_pkg::STAT_OK;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= 5; k++) v_ff[k] <= 1'b0;
         for (int k = 0; k < DL; k++) sb_v_ff[k] <= 1'b0;
      end else if (en) begin
         v_ff[1] <= req_tvalid;
         for (int k = 2; k <= 5; k++) v_ff[k] <= v_ff[k-1];
         sb_v_ff[0] <= v_ff[5];
         for (int k = 1; k < DL; k++) sb_v_ff[k] <= sb_v_ff[k-1];
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (en) begin
         cmd_ff[1] <= req_tuser;
         s_ff[1]   <= req_tdata[8*DW +: DW];
         for (int c = 0; c < NL; c++) begin
            l1_ff[c] <= req_tdata[c*DW +: DW];
            r1_ff[c] <= req_tdata[(c+NL)*DW +: DW];
         end
         for (int k = 2; k <= 5; k++) begin
            cmd_ff[k] <= cmd_ff[k-1];
            s_ff[k]   <= s_ff[k-1];
         end
         wl_ff[2] <= l1_ff[3];
         for (int k = 3; k <= 5; k++) wl_ff[k] <= wl_ff[k-1];
         for (int c = 0; c < NL; c++) begin
            for (int k = 0; k < NT; k++) begin
               prod2_ff[c][k] <= PW'(a_op[c][k]) * PW'(b_op[c][k]);
               neg2_ff[c][k]  <= n_op[c][k];
            end
            pair3_ff[c][0] <= term_in[c][0] + term_in[c][1];
            pair3_ff[c][1] <= term_in[c][2] + term_in[c][3];
            sum4_ff[c]     <= pair3_ff[c][0] + pair3_ff[c][1] + RND;
            mac5_ff[c]     <= mac5_in[c];
            mov5_ff[c]     <= mov5_in[c];
         end
         sb_dz_ff[0] <= dz_in;
         sb_ov_ff[0] <= ov_in;
         for (int k = 1; k < DL; k++) begin
            sb_dz_ff[k] <= sb_dz_ff[k-1];
            sb_ov_ff[k] <= sb_ov_ff[k-1];
         end
      end
   end

   // output register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= deliver;
         end
      end else if (deliver) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
            out_stat_ff <= skid_stat_ff;
         end else if (deliver) begin
            out_data_ff <= res_in;
            out_stat_ff <= stat_in;
         end
      end else if (deliver) begin
         skid_data_ff <= res_in;
         skid_stat_ff <= stat_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_stat_ff;

   `QALU_ASSERT_NOW(a_dz_zero, rsp_tvalid && rsp_tuser == qalu_pkg::STAT_DZ, rsp_tdata == '0, "divide by zero beat carries nonzero data")
   `QALU_ASSERT_NOW(a_skid_out, skid_valid_ff, out_valid_ff, "skid entry held without an output beat")
   `QALU_ASSERT_NEXT(a_skid_fill, out_valid_ff && !rsp_tready && deliver, skid_valid_ff, "result dropped while output stalled")

endmodule

`default_nettype wire
